// ===== sv/cdll_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdll_pkg
// Command and status codes, plus the control and status bundles passed
// between the sequencer and the datapath of the linked list engine.
// ----------------------------------------------------------------------------
package cdll_pkg;

  localparam logic [3:0] CMD_INS_HEAD   = 4'd0;
  localparam logic [3:0] CMD_INS_TAIL   = 4'd1;
  localparam logic [3:0] CMD_INS_AFTER  = 4'd2;
  localparam logic [3:0] CMD_INS_BEFORE = 4'd3;
  localparam logic [3:0] CMD_DEL_BACK   = 4'd4;
  localparam logic [3:0] CMD_DEL_FWD    = 4'd5;
  localparam logic [3:0] CMD_REM_BACK   = 4'd6;
  localparam logic [3:0] CMD_REM_FWD    = 4'd7;
  localparam logic [3:0] CMD_GO_HEAD    = 4'd8;
  localparam logic [3:0] CMD_GO_TAIL    = 4'd9;
  localparam logic [3:0] CMD_CURRENT    = 4'd10;
  localparam logic [3:0] CMD_NEXT       = 4'd11;
  localparam logic [3:0] CMD_PREV       = 4'd12;
  localparam logic [3:0] CMD_CLEAR      = 4'd13;

  localparam logic [1:0] ST_DATA   = 2'd0;
  localparam logic [1:0] ST_NODATA = 2'd1;
  localparam logic [1:0] ST_NOCUR  = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  // one phase strobe per sequencer step
  typedef struct packed {
    logic load;
    logic rd_free;
    logic rd_cur;
    logic exec;
    logic link;
    logic fin;
  } ctl_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

// ===== sv/cursor_doubly_linked_list_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_doubly_linked_list_engine
// Bounded doubly linked list with a cursor, held in a node pool.
//
//   channel  direction  handshake              word
//   in       input      in_valid / in_ready    cmd, payload_in
//   out      output     out_valid / out_ready  status, payload_out,
//                                              entry_count, cursor_valid
//
// After acceptance a command walks through five phases to the result
// register: free chain read, cursor read, node write, neighbour link write, result.
// A new word is accepted only once the previous one has left the result phase.
// The single read port of the pool memories sets that sequence.
// Reset is synchronous; pool memories need no clearing pass.
// A result waiting on out_ready holds the sequencer in its last phase.
// ----------------------------------------------------------------------------
module cursor_doubly_linked_list_engine
  import cdll_pkg::*;
#(
  parameter int CAPACITY      = 64,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  cmd,
  input  logic [31:0] payload_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] payload_out,
  output logic [6:0]  entry_count,
  output logic        cursor_valid
);

  ctl_t ctl;
  sts_t sts;

  cdll_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  cdll_datapath #(
    .CAPACITY      (CAPACITY),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .sts          (sts),
    .cmd          (cmd),
    .payload_in   (payload_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .payload_out  (payload_out),
    .entry_count  (entry_count),
    .cursor_valid (cursor_valid)
  );

endmodule

// ===== sv/cdll_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdll_ctrl
// Command sequencer: walks each word through free-chain read, cursor read,
// node write, neighbour link write and result phases.
// ----------------------------------------------------------------------------
module cdll_ctrl
  import cdll_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output ctl_t ctl
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDF  = 3'd1;
  localparam logic [2:0] S_RDC  = 3'd2;
  localparam logic [2:0] S_EXEC = 3'd3;
  localparam logic [2:0] S_LINK = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    ctl.load    = in_valid && in_ready;
    ctl.rd_free = (state == S_RDF);
    ctl.rd_cur  = (state == S_RDC);
    ctl.exec    = (state == S_EXEC);
    ctl.link    = (state == S_LINK);
    ctl.fin     = (state == S_FIN);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_RDF;
      S_RDF:  state_next = S_RDC;
      S_RDC:  state_next = S_EXEC;
      S_EXEC: state_next = S_LINK;
      S_LINK: state_next = S_FIN;
      S_FIN:  if (sts.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

// ===== sv/cdll_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdll_datapath
// Node pool memories, list and cursor registers, free chain and the
// output register.
// ----------------------------------------------------------------------------
module cdll_datapath
  import cdll_pkg::*;
#(
  parameter int CAPACITY      = 64,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  ctl_t        ctl,
  output sts_t        sts,
  input  logic [3:0]  cmd,
  input  logic [31:0] payload_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] payload_out,
  output logic [6:0]  entry_count,
  output logic        cursor_valid
);

  localparam int LW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int SW = (PAYLOAD_WIDTH < 32) ? PAYLOAD_WIDTH : 32;
  localparam logic [LW-1:0] NONE = LW'(CAPACITY);

  logic [SW-1:0] mem_pay  [CAPACITY];
  logic [LW-1:0] mem_next [CAPACITY];
  logic [LW-1:0] mem_prev [CAPACITY];

  logic [LW-1:0] head, tail, cur, cnt, fhead, fresh;
  logic [3:0]    cmd_q;
  logic [SW-1:0] data_q, val_q;
  logic [LW-1:0] c_q, n_q, t_q;
  logic [1:0]    st_q;
  logic          ok_q;

  logic [AW-1:0] rd_addr;
  logic [LW-1:0] rd_link;
  logic          rd_en;
  logic [SW-1:0] rd_pay;
  logic [LW-1:0] rd_next, rd_prev;

  logic          pay_we, next_we, prev_we;
  logic [LW-1:0] pay_wa, next_wa, prev_wa;
  logic [LW-1:0] next_wd, prev_wd;

  logic          is_ins, is_del, fire;
  logic [1:0]    res_st;
  logic [SW-1:0] res_val;

  function automatic logic live(input logic [LW-1:0] x);
    return x < NONE;
  endfunction

  always_comb begin
    is_ins = cmd_q inside {CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AFTER, CMD_INS_BEFORE};
    is_del = cmd_q inside {CMD_DEL_BACK, CMD_DEL_FWD, CMD_REM_BACK, CMD_REM_FWD};
  end

  // single read port shared by all three arrays
  always_comb begin
    if (ctl.rd_free)     rd_link = fhead;
    else if (ctl.rd_cur) rd_link = c_q;
    else                 rd_link = t_q;
    rd_en   = ctl.rd_free || ctl.rd_cur || ctl.link;
    rd_addr = live(rd_link) ? rd_link[AW-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_pay  <= mem_pay[rd_addr];
      rd_next <= mem_next[rd_addr];
      rd_prev <= mem_prev[rd_addr];
    end
  end

  // write ports: node body (insert) or neighbour unlinks (delete) in exec, links in link phase
  always_comb begin
    pay_we  = 1'b0;
    next_we = 1'b0;
    prev_we = 1'b0;
    pay_wa  = n_q;
    next_wa = n_q;
    prev_wa = n_q;
    next_wd = NONE;
    prev_wd = NONE;
    if (ctl.exec && is_ins && ok_q) begin
      pay_we  = 1'b1;
      next_we = 1'b1;
      prev_we = 1'b1;
      case (cmd_q)
        CMD_INS_HEAD:  begin next_wd = head;    prev_wd = NONE;    end
        CMD_INS_TAIL:  begin next_wd = NONE;    prev_wd = tail;    end
        CMD_INS_AFTER: begin next_wd = rd_next; prev_wd = c_q;     end
        default:       begin next_wd = c_q;     prev_wd = rd_prev; end
      endcase
    end else if (ctl.exec && is_del && live(c_q)) begin
      next_we = live(rd_prev);
      next_wa = rd_prev;
      next_wd = rd_next;
      prev_we = live(rd_next);
      prev_wa = rd_next;
      prev_wd = rd_prev;
    end else if (ctl.link && is_ins && ok_q) begin
      next_wd = n_q;
      prev_wd = n_q;
      if (cmd_q == CMD_INS_BEFORE) begin
        prev_we = 1'b1;
        prev_wa = c_q;
      end else if (cmd_q == CMD_INS_HEAD || cmd_q == CMD_INS_AFTER) begin
        prev_we = live(t_q);
        prev_wa = t_q;
      end
      if (cmd_q == CMD_INS_AFTER) begin
        next_we = 1'b1;
        next_wa = c_q;
      end else if (cmd_q == CMD_INS_TAIL || cmd_q == CMD_INS_BEFORE) begin
        next_we = live(t_q);
        next_wa = t_q;
      end
    end else if (ctl.link && is_del && live(c_q)) begin
      // freed node goes on the front of the free chain
      next_we = 1'b1;
      next_wa = c_q;
      next_wd = fhead;
    end
  end

  always_ff @(posedge clk) begin
    if (pay_we)  mem_pay[pay_wa[AW-1:0]]   <= data_q;
    if (next_we) mem_next[next_wa[AW-1:0]] <= next_wd;
    if (prev_we) mem_prev[prev_wa[AW-1:0]] <= prev_wd;
  end

  // result of the finished command
  always_comb begin
    res_st  = ST_NODATA;
    res_val = rd_pay;
    if (is_ins) begin
      res_st = st_q;
    end else if (is_del) begin
      if (!live(c_q)) res_st = ST_NOCUR;
      else if (cmd_q == CMD_REM_BACK || cmd_q == CMD_REM_FWD) begin
        res_st  = ST_DATA;
        res_val = val_q;
      end else if (live(t_q)) res_st = ST_DATA;
    end else if (cmd_q inside {[CMD_GO_HEAD:CMD_PREV]}) begin
      if (live(t_q)) res_st = ST_DATA;
    end
  end

  assign fire         = ctl.fin && sts.out_free;
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q  <= cmd;
      data_q <= payload_in[SW-1:0];
      c_q    <= cur;
    end
    if (fire) begin
      status       <= res_st;
      payload_out  <= (res_st == ST_DATA) ? 32'(res_val) : '0;
      entry_count  <= 7'(cnt);
      cursor_valid <= live(cur);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= NONE;
      tail      <= NONE;
      cur       <= NONE;
      fhead     <= NONE;
      cnt       <= '0;
      fresh     <= '0;
      ok_q      <= 1'b0;
      st_q      <= ST_NODATA;
      n_q       <= NONE;
      t_q       <= NONE;
      val_q     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.rd_cur && is_ins) begin
        // allocate: free chain first, then never-used nodes
        ok_q <= 1'b0;
        st_q <= ST_NODATA;
        if ((cmd_q == CMD_INS_AFTER || cmd_q == CMD_INS_BEFORE) && !live(c_q)) begin
          st_q <= ST_NOCUR;
        end else if (live(fhead)) begin
          n_q   <= fhead;
          fhead <= rd_next;
          cnt   <= cnt + LW'(1);
          ok_q  <= 1'b1;
        end else if (fresh < NONE) begin
          n_q   <= fresh;
          fresh <= fresh + LW'(1);
          cnt   <= cnt + LW'(1);
          ok_q  <= 1'b1;
        end else begin
          st_q <= ST_FULL;
        end
      end
      if (ctl.exec) begin
        case (cmd_q)
          CMD_INS_HEAD: if (ok_q) begin
            t_q  <= head;
            head <= n_q;
            if (!live(head)) tail <= n_q;
          end
          CMD_INS_TAIL: if (ok_q) begin
            t_q  <= tail;
            tail <= n_q;
            if (!live(tail)) head <= n_q;
          end
          CMD_INS_AFTER: if (ok_q) begin
            t_q <= rd_next;
            if (!live(rd_next)) tail <= n_q;
          end
          CMD_INS_BEFORE: if (ok_q) begin
            t_q <= rd_prev;
            if (!live(rd_prev)) head <= n_q;
          end
          CMD_DEL_BACK, CMD_DEL_FWD, CMD_REM_BACK, CMD_REM_FWD: begin
            if (live(c_q)) begin
              if (!live(rd_prev)) head <= rd_next;
              if (!live(rd_next)) tail <= rd_prev;
              if (cnt != '0) cnt <= cnt - LW'(1);
              val_q <= rd_pay;
              if (cmd_q == CMD_DEL_BACK || cmd_q == CMD_REM_BACK) begin
                t_q <= rd_prev;
                cur <= rd_prev;
              end else begin
                t_q <= rd_next;
                cur <= rd_next;
              end
            end else begin
              t_q <= NONE;
            end
          end
          CMD_GO_HEAD: begin
            t_q <= head;
            if (live(head)) cur <= head;
          end
          CMD_GO_TAIL: begin
            t_q <= tail;
            if (live(tail)) cur <= tail;
          end
          CMD_CURRENT: t_q <= c_q;
          CMD_NEXT, CMD_PREV: begin
            if (live(c_q)) begin
              t_q <= (cmd_q == CMD_NEXT) ? rd_next : rd_prev;
              cur <= (cmd_q == CMD_NEXT) ? rd_next : rd_prev;
            end else begin
              t_q <= NONE;
            end
          end
          CMD_CLEAR: begin
            head  <= NONE;
            tail  <= NONE;
            cur   <= NONE;
            fhead <= NONE;
            cnt   <= '0;
            fresh <= '0;
            t_q   <= NONE;
          end
          default: t_q <= NONE;
        endcase
      end
      if (ctl.link && is_del && live(c_q)) fhead <= c_q;
      if (fire)           out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= NONE)
    else $error("entry count beyond pool size");
  a_ends_agree: assert property (@(posedge clk) disable iff (rst)
    live(head) == live(tail))
    else $error("head and tail disagree on emptiness");
  // count rises at allocation, ahead of the head update
  a_empty_cnt: assert property (@(posedge clk) disable iff (rst)
    (cnt == '0) |-> !live(head))
    else $error("empty count with a live head");
  a_cur_nonempty: assert property (@(posedge clk) disable iff (rst)
    live(cur) |-> (cnt != '0))
    else $error("cursor set on an empty list");
  a_fin_held: assert property (@(posedge clk) disable iff (rst)
    (ctl.fin && !sts.out_free) |=> $stable(status) && $stable(payload_out))
    else $error("pending result overwritten");
`endif

endmodule

// ===== tb/cursor_doubly_linked_list_engine_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_doubly_linked_list_engine_tb
// Drives command words into the list engine and checks every result word
// against a behavioural list model kept inside the bench. A directed table
// covers the empty list, refused commands and clear; the pool is then filled
// past full; random traffic builds and tears down lists, idling on both sides.
// ----------------------------------------------------------------------------
module cursor_doubly_linked_list_engine_tb;
  import cdll_pkg::*;

  localparam int NODES = 64;
  localparam logic [6:0] NIL = 7'd64;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [1:0]  st;
    logic [31:0] data;
    logic [6:0]  cnt;
    logic        cur;
  } answer_t;

  typedef struct {
    logic [3:0]  op;
    logic [31:0] word;
    logic        fixed;  // expected answer typed in below
    answer_t     ans;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [3:0]  cmd = CMD_CLEAR;
  logic [31:0] payload_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [31:0] payload_out;
  logic [6:0]  entry_count;
  logic        cursor_valid;

  cursor_doubly_linked_list_engine dut (.*);

  always #1 clk = ~clk;

  // bench copy of the pool
  logic [31:0] pool_data [NODES];
  logic [6:0]  fwd_link [NODES];
  logic [6:0]  back_link [NODES];
  logic [6:0]  head_ix, tail_ix, cur_ix, free_ix, fresh_ix, n_items;

  answer_t pending_answers[$];
  answer_t typed_answers[$];
  bit      typed_flags[$];
  int      errors = 0;
  bit      calm = 0;  // no idling while set
  int      stall_cycles = 0;

  function automatic void wipe_list();
    head_ix = NIL; tail_ix = NIL; cur_ix = NIL; free_ix = NIL;
    fresh_ix = 0; n_items = 0;
  endfunction

  function automatic logic [6:0] grab_node(logic [31:0] w);
    logic [6:0] n;
    if (free_ix != NIL) begin
      n = free_ix;
      free_ix = fwd_link[n];
    end else if (fresh_ix < NIL) begin
      n = fresh_ix;
      fresh_ix++;
    end else begin
      return NIL;
    end
    pool_data[n] = w; fwd_link[n] = NIL; back_link[n] = NIL;
    n_items++;
    return n;
  endfunction

  function automatic void drop_node(logic [6:0] n);
    logic [6:0] p, q;
    p = back_link[n];
    q = fwd_link[n];
    if (p != NIL) fwd_link[p] = q; else head_ix = q;
    if (q != NIL) back_link[q] = p; else tail_ix = p;
    fwd_link[n] = free_ix;
    free_ix = n;
    n_items--;
  endfunction

  function automatic answer_t list_answer(logic [3:0] op, logic [31:0] w);
    answer_t a;
    logic [6:0] n, t, c;
    c = cur_ix;
    a.st = ST_NODATA;
    a.data = '0;
    case (op)
      CMD_INS_HEAD, CMD_INS_TAIL: begin
        n = grab_node(w);
        if (n == NIL) a.st = ST_FULL;
        else if (op == CMD_INS_HEAD) begin
          fwd_link[n] = head_ix;
          if (head_ix != NIL) back_link[head_ix] = n; else tail_ix = n;
          head_ix = n;
        end else begin
          back_link[n] = tail_ix;
          if (tail_ix != NIL) fwd_link[tail_ix] = n; else head_ix = n;
          tail_ix = n;
        end
      end
      CMD_INS_AFTER, CMD_INS_BEFORE: begin
        if (c == NIL) a.st = ST_NOCUR;
        else begin
          n = grab_node(w);
          if (n == NIL) a.st = ST_FULL;
          else if (op == CMD_INS_AFTER) begin
            t = fwd_link[c];
            back_link[n] = c; fwd_link[n] = t;
            if (t != NIL) back_link[t] = n; else tail_ix = n;
            fwd_link[c] = n;
          end else begin
            t = back_link[c];
            fwd_link[n] = c; back_link[n] = t;
            if (t != NIL) fwd_link[t] = n; else head_ix = n;
            back_link[c] = n;
          end
        end
      end
      CMD_DEL_BACK, CMD_DEL_FWD, CMD_REM_BACK, CMD_REM_FWD: begin
        if (c == NIL) a.st = ST_NOCUR;
        else begin
          t = (op == CMD_DEL_BACK || op == CMD_REM_BACK) ? back_link[c] : fwd_link[c];
          a.data = pool_data[c];
          drop_node(c);
          cur_ix = t;
          if (op == CMD_REM_BACK || op == CMD_REM_FWD) a.st = ST_DATA;
          else if (t != NIL) begin
            a.st = ST_DATA;
            a.data = pool_data[t];
          end
        end
      end
      CMD_GO_HEAD, CMD_GO_TAIL: begin
        t = (op == CMD_GO_HEAD) ? head_ix : tail_ix;
        if (t != NIL) begin
          cur_ix = t; a.st = ST_DATA; a.data = pool_data[t];
        end
      end
      CMD_CURRENT:
        if (c != NIL) begin
          a.st = ST_DATA; a.data = pool_data[c];
        end
      CMD_NEXT, CMD_PREV:
        if (c != NIL) begin
          t = (op == CMD_NEXT) ? fwd_link[c] : back_link[c];
          cur_ix = t;
          if (t != NIL) begin
            a.st = ST_DATA; a.data = pool_data[t];
          end
        end
      CMD_CLEAR: wipe_list();
      default: ;
    endcase
    if (a.st != ST_DATA) a.data = '0;
    a.cnt = n_items;
    a.cur = (cur_ix != NIL);
    return a;
  endfunction

  // send one word; the prediction is made once the word is accepted.
  // valid stays up into the next word unless an idle cycle is taken.
  task automatic send_word(logic [3:0] op, logic [31:0] w, bit fixed, answer_t typed);
    while (!calm && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    cmd <= op;
    payload_in <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_answers.push_back(list_answer(op, w));
    typed_flags.push_back(fixed);
    typed_answers.push_back(typed);
  endtask

  always @(posedge clk) begin
    if (!rst) out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 14);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      answer_t got, want, typed;
      bit fixed;
      got = '{status, payload_out, entry_count, cursor_valid};
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, got);
        errors++;
      end else begin
        want = pending_answers.pop_front();
        typed = typed_answers.pop_front();
        fixed = typed_flags.pop_front();
        if (fixed && typed != want) begin
          $display("%0t: table row disagrees with model: exp %h model %h",
                   $time, typed, want);
          errors++;
        end
        if (got.st != want.st) begin
          $display("%0t: status exp %0d got %0d", $time, want.st, got.st); errors++;
        end
        if (got.data != want.data) begin
          $display("%0t: payload exp %h got %h", $time, want.data, got.data); errors++;
        end
        if (got.cnt != want.cnt) begin
          $display("%0t: count exp %0d got %0d", $time, want.cnt, got.cnt); errors++;
        end
        if (got.cur != want.cur) begin
          $display("%0t: cursor exp %0b got %0b", $time, want.cur, got.cur); errors++;
        end
      end
    end
  end

  // watchdog on cycles with nothing accepted
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic answer_t mk(logic [1:0] st, logic [31:0] d, logic [6:0] c, logic cv);
    answer_t a;
    a = '{st, d, c, cv};
    return a;
  endfunction

  function automatic logic [3:0] pick_op();
    int r;
    r = $urandom_range(99);
    if (r < 22) return $urandom_range(1) ? CMD_INS_HEAD : CMD_INS_TAIL;
    if (r < 40) return $urandom_range(1) ? CMD_INS_AFTER : CMD_INS_BEFORE;
    if (r < 55) return 4'($urandom_range(CMD_REM_FWD, CMD_DEL_BACK));
    if (r < 95) return 4'($urandom_range(CMD_PREV, CMD_GO_HEAD));
    if (r < 97) return CMD_CLEAR;
    return 4'($urandom_range(15, 14));
  endfunction

  initial begin
    row_t table_rows[$];
    answer_t none_ans;
    logic [31:0] w;
    int phase;
    none_ans = '0;
    wipe_list();

    // empty list, refused commands, extremes of the payload word
    table_rows.push_back('{CMD_CURRENT,    32'h0,        1, mk(ST_NODATA, 0, 0, 0)});
    table_rows.push_back('{CMD_PREV,       32'h0,        1, mk(ST_NODATA, 0, 0, 0)});
    table_rows.push_back('{CMD_NEXT,       32'h0,        1, mk(ST_NODATA, 0, 0, 0)});
    table_rows.push_back('{CMD_GO_HEAD,    32'h0,        1, mk(ST_NODATA, 0, 0, 0)});
    table_rows.push_back('{CMD_INS_AFTER,  32'h1,        1, mk(ST_NOCUR, 0, 0, 0)});
    table_rows.push_back('{CMD_INS_BEFORE, 32'h1,        1, mk(ST_NOCUR, 0, 0, 0)});
    table_rows.push_back('{CMD_DEL_BACK,   32'h0,        1, mk(ST_NOCUR, 0, 0, 0)});
    table_rows.push_back('{CMD_REM_FWD,    32'h0,        1, mk(ST_NOCUR, 0, 0, 0)});
    table_rows.push_back('{CMD_INS_HEAD,   32'hFFFFFFFF, 1, mk(ST_NODATA, 0, 1, 0)});
    table_rows.push_back('{CMD_INS_TAIL,   32'h00000000, 1, mk(ST_NODATA, 0, 2, 0)});
    table_rows.push_back('{CMD_GO_HEAD,    32'h0,        1, mk(ST_DATA, 32'hFFFFFFFF, 2, 1)});
    table_rows.push_back('{CMD_INS_BEFORE, 32'hA5A5A5A5, 0, none_ans});
    table_rows.push_back('{CMD_INS_AFTER,  32'h5A5A5A5A, 0, none_ans});
    table_rows.push_back('{CMD_PREV,       32'h0,        0, none_ans});
    table_rows.push_back('{CMD_GO_TAIL,    32'h0,        1, mk(ST_DATA, 32'h0, 4, 1)});
    table_rows.push_back('{CMD_NEXT,       32'h0,        1, mk(ST_NODATA, 0, 4, 0)});
    table_rows.push_back('{CMD_GO_TAIL,    32'h0,        0, none_ans});
    table_rows.push_back('{CMD_DEL_FWD,    32'h0,        1, mk(ST_NODATA, 0, 3, 0)});
    table_rows.push_back('{CMD_GO_HEAD,    32'h0,        0, none_ans});
    table_rows.push_back('{CMD_REM_FWD,    32'h0,        1, mk(ST_DATA, 32'hA5A5A5A5, 2, 1)});
    table_rows.push_back('{CMD_DEL_BACK,   32'h0,        1, mk(ST_NODATA, 0, 1, 0)});
    table_rows.push_back('{CMD_GO_HEAD,    32'h0,        0, none_ans});
    table_rows.push_back('{CMD_REM_BACK,   32'h0,        0, none_ans});
    table_rows.push_back('{4'd15,          32'h0,        1, mk(ST_NODATA, 0, 0, 0)});
    table_rows.push_back('{CMD_CLEAR,      32'h0,        1, mk(ST_NODATA, 0, 0, 0)});

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (table_rows[i])
      send_word(table_rows[i].op, table_rows[i].word, table_rows[i].fixed,
                table_rows[i].ans);

    // fill the pool and push one past full, then wipe it
    for (int i = 0; i < NODES; i++) send_word(CMD_INS_TAIL, $urandom, 0, none_ans);
    send_word(CMD_INS_HEAD, 32'h1234, 1, mk(ST_FULL, 0, 64, 0));
    send_word(CMD_GO_HEAD, 0, 0, none_ans);
    send_word(CMD_INS_AFTER, 32'h1234, 1, mk(ST_FULL, 0, 64, 1));
    send_word(CMD_CLEAR, 0, 1, mk(ST_NODATA, 0, 0, 0));

    for (int i = 0; i < 1900; i++) begin
      calm = (i >= 600 && i < 900);
      phase = $urandom_range(3);
      case (phase)
        0: w = $urandom;
        1: w = 32'hFFFFFFFF >> $urandom_range(31);
        2: w = 32'h1 << $urandom_range(31);
        default: w = $urandom_range(255);
      endcase
      send_word(pick_op(), w, 0, none_ans);
    end
    calm = 0;
    in_valid <= 1'b0;

    while (pending_answers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
